FILE: src/cpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpg_pkg
// shared constants for the circle packing growth pass block
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int MAX_CIRCLES_DEF = 64;
  localparam int FRAC_BITS_DEF   = 24;

  // configuration register indexes
  localparam logic [7:0] REG_RVE_SIZE      = 8'd0;
  localparam logic [7:0] REG_GROWTH_FACTOR = 8'd1;
  localparam logic [7:0] REG_STOP_FRACTION = 8'd2;
  localparam logic [7:0] REG_MAX_PASSES    = 8'd3;

  // reset values of the registers
  localparam logic [31:0] RVE_SIZE_RST      = 32'd1677722;
  localparam logic [15:0] GROWTH_FACTOR_RST = 16'd62259;
  localparam logic [15:0] STOP_FRACTION_RST = 16'd66;
  localparam logic [7:0]  MAX_PASSES_RST    = 8'd10;

endpackage
`default_nettype wire

FILE: src/circle_packing_grow_pass_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_packing_grow_pass_top
// loads circles, runs diameter growth passes, then emits the grown set
// ----------------------------------------------------------------------------
// usage
//   input channel: one circle per request (center_x, center_y, radius_in, last_in).
//   circles whose centre lies outside [0, rve_size]^2, or that arrive with the
//   set full, are dropped. a request without last_in gives no result.
//   after the request with last_in the block stops taking requests and runs up
//   to max_passes growth passes. each pair check takes two squares through the
//   shared 34x32 multiplier, then a 33 step bit-serial square root; each
//   circle adds the squares of its old and new diameter and its growth step.
//   each pass ends with a stop test against stop_fraction.
//   the output channel then carries one result per stored circle in load
//   order, last_out on the final one; an empty set gives a single result with
//   none_stored set.
//   when the receiver stalls the result register holds until taken.
//   configuration writes are taken in any cycle (cfg_ready is tied high).
//   reset (synchronous) clears the set, the pass count and the registers to
//   their defaults; the circle stores themselves are not cleared.
// ----------------------------------------------------------------------------
module circle_packing_grow_pass_top #(
  parameter int MAX_CIRCLES = cpg_pkg::MAX_CIRCLES_DEF,
  parameter int FRAC_BITS   = cpg_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] center_x,
  input  wire logic [31:0] center_y,
  input  wire logic [31:0] radius_in,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_radius,
  output logic             last_out,
  output logic             none_stored,
  output logic [7:0]       passes_done
);

  localparam int IDX_W = $clog2(MAX_CIRCLES);
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CIRCLES);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PSTART = 5'd1;
  localparam logic [4:0] S_ISTART = 5'd2;
  localparam logic [4:0] S_ILATCH = 5'd3;
  localparam logic [4:0] S_ISQ    = 5'd4;
  localparam logic [4:0] S_IOLD   = 5'd5;
  localparam logic [4:0] S_JCHK   = 5'd6;
  localparam logic [4:0] S_JLATCH = 5'd7;
  localparam logic [4:0] S_DX     = 5'd8;
  localparam logic [4:0] S_DY     = 5'd9;
  localparam logic [4:0] S_SUM    = 5'd10;
  localparam logic [4:0] S_SQRT   = 5'd11;
  localparam logic [4:0] S_SPACE  = 5'd12;
  localparam logic [4:0] S_GROW   = 5'd13;
  localparam logic [4:0] S_NEW    = 5'd14;
  localparam logic [4:0] S_NSQ    = 5'd15;
  localparam logic [4:0] S_NACC   = 5'd16;
  localparam logic [4:0] S_PEND   = 5'd17;
  localparam logic [4:0] S_RLO    = 5'd18;
  localparam logic [4:0] S_RHI    = 5'd19;
  localparam logic [4:0] S_CMP    = 5'd20;
  localparam logic [4:0] S_EMIT   = 5'd21;
  localparam logic [4:0] S_EREAD  = 5'd22;
  localparam logic [4:0] S_ELOAD  = 5'd23;
  localparam logic [4:0] S_EWAIT  = 5'd24;

  logic [4:0] state;

  // configuration
  logic [31:0] rve_size;
  logic [15:0] growth_factor;
  logic [15:0] stop_fraction;
  logic [7:0]  max_passes;

  // circle stores
  logic [31:0] x_mem [MAX_CIRCLES];
  logic [31:0] y_mem [MAX_CIRCLES];
  logic [31:0] d_mem [MAX_CIRCLES];
  logic [31:0] rx, ry, rd;
  logic [IDX_W-1:0] raddr;
  logic             we_load, we_grow;

  logic [CNT_W-1:0] circle_count, i_cnt, j_cnt, e_cnt;
  logic [7:0]       pass_count;
  logic [63:0]      old_sum, new_sum;
  logic [31:0]      xi, yi, di, xj, yj, dj, nd;
  logic [31:0]      dx, dy;
  logic [63:0]      sq_acc;
  logic [65:0]      s_reg;
  logic [35:0]      rem;
  logic [32:0]      root;
  logic [5:0]       sq_cnt;
  logic signed [35:0] gap;
  logic             found;
  logic [47:0]      rlo;

  // shared multiplier, result registered
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;

  logic accept_in, store_ok;
  logic [31:0] d_load;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign store_ok  = (center_x <= rve_size) && (center_y <= rve_size) &&
                     (circle_count < MAX_CNT);
  assign we_load   = accept_in && store_ok;
  assign we_grow   = (state == S_NSQ);
  assign d_load    = radius_in[31] ? 32'hFFFF_FFFF : {radius_in[30:0], 1'b0};

  always_comb begin
    raddr = e_cnt[IDX_W-1:0];
    case (state)
      S_ISTART: raddr = i_cnt[IDX_W-1:0];
      S_JCHK:   raddr = j_cnt[IDX_W-1:0];
      default:  raddr = e_cnt[IDX_W-1:0];
    endcase
  end

  always_comb begin
    mul_a = 34'd0;
    mul_b = 32'd0;
    case (state)
      S_ISQ:  begin mul_a = {2'b0, di}; mul_b = di; end
      S_DX:   begin mul_a = {2'b0, dx}; mul_b = dx; end
      S_DY:   begin mul_a = {2'b0, dy}; mul_b = dy; end
      S_GROW: begin
        mul_a = gap[35] ? 34'(-gap) : gap[33:0];
        mul_b = {16'b0, growth_factor};
      end
      S_NSQ:  begin mul_a = {2'b0, nd}; mul_b = nd; end
      S_RLO:  begin mul_a = {18'b0, stop_fraction}; mul_b = old_sum[31:0]; end
      S_RHI:  begin mul_a = {18'b0, stop_fraction}; mul_b = old_sum[63:32]; end
      default: begin mul_a = 34'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_load) begin
      x_mem[circle_count[IDX_W-1:0]] <= center_x;
      y_mem[circle_count[IDX_W-1:0]] <= center_y;
      d_mem[circle_count[IDX_W-1:0]] <= d_load;
    end else if (we_grow) begin
      d_mem[i_cnt[IDX_W-1:0]] <= nd;
    end
    rx <= x_mem[raddr];
    ry <= y_mem[raddr];
    rd <= d_mem[raddr];
  end

  // datapath helpers
  logic [63:0] term;
  logic [64:0] old_add, new_add, sq_sum;
  logic [35:0] rem_sh, trial;
  logic [32:0] sum_d;
  logic signed [35:0] space;
  logic [33:0] delta;
  logic signed [35:0] nd_wide;
  logic [63:0] sum_diff;
  logic [79:0] lhs, rhs;

  assign term     = prod[63:0] >> FRAC_BITS;
  assign old_add  = {1'b0, old_sum} + {1'b0, term};
  assign new_add  = {1'b0, new_sum} + {1'b0, term};
  assign sq_sum   = {1'b0, sq_acc} + {1'b0, prod[63:0]};
  assign rem_sh   = {rem[33:0], s_reg[65:64]};
  assign trial    = {1'b0, root, 2'b01};
  assign sum_d    = {1'b0, di} + {1'b0, dj};
  assign space    = $signed({3'b0, root}) - $signed({4'b0, sum_d[32:1]});
  assign delta    = prod[49:16];
  assign nd_wide  = gap[35] ? $signed({4'b0, di}) - $signed({2'b0, delta})
                            : $signed({4'b0, di}) + $signed({2'b0, delta});
  assign sum_diff = new_sum - old_sum;
  assign lhs      = {sum_diff, 16'b0};
  assign rhs      = {prod[47:0], 32'b0} + {32'b0, rlo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rve_size      <= cpg_pkg::RVE_SIZE_RST;
      growth_factor <= cpg_pkg::GROWTH_FACTOR_RST;
      stop_fraction <= cpg_pkg::STOP_FRACTION_RST;
      max_passes    <= cpg_pkg::MAX_PASSES_RST;
      circle_count  <= '0;
      pass_count    <= '0;
      old_sum       <= '0;
      new_sum       <= '0;
      out_valid     <= 1'b0;
      i_cnt         <= '0;
      j_cnt         <= '0;
      e_cnt         <= '0;
      sq_cnt        <= '0;
      found         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          cpg_pkg::REG_RVE_SIZE:      rve_size      <= cfg_data;
          cpg_pkg::REG_GROWTH_FACTOR: growth_factor <= cfg_data[15:0];
          cpg_pkg::REG_STOP_FRACTION: stop_fraction <= cfg_data[15:0];
          cpg_pkg::REG_MAX_PASSES:    max_passes    <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            if (store_ok) circle_count <= circle_count + 1'b1;
            if (last_in) begin
              pass_count <= '0;
              state      <= S_PSTART;
            end
          end
        end
        S_PSTART: begin
          if (pass_count < max_passes) begin
            old_sum <= '0;
            new_sum <= '0;
            i_cnt   <= '0;
            state   <= (circle_count == '0) ? S_PEND : S_ISTART;
          end else begin
            state <= S_EMIT;
          end
        end
        S_ISTART: state <= S_ILATCH;
        S_ILATCH: begin
          xi    <= rx;
          yi    <= ry;
          di    <= rd;
          state <= S_ISQ;
        end
        S_ISQ: state <= S_IOLD;
        S_IOLD: begin
          old_sum <= old_add[64] ? '1 : old_add[63:0];
          j_cnt   <= '0;
          found   <= 1'b0;
          gap     <= '0;
          state   <= S_JCHK;
        end
        S_JCHK: begin
          if (j_cnt == circle_count) state <= S_GROW;
          else if (j_cnt == i_cnt) j_cnt <= j_cnt + 1'b1;
          else state <= S_JLATCH;
        end
        S_JLATCH: begin
          dj    <= rd;
          dx    <= (xi >= rx) ? xi - rx : rx - xi;
          dy    <= (yi >= ry) ? yi - ry : ry - yi;
          state <= S_DX;
        end
        S_DX: state <= S_DY;
        S_DY: begin
          sq_acc <= prod[63:0];
          state  <= S_SUM;
        end
        S_SUM: begin
          s_reg  <= {1'b0, sq_sum};
          rem    <= '0;
          root   <= '0;
          sq_cnt <= 6'd33;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle, restoring
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          s_reg  <= {s_reg[63:0], 2'b00};
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_cnt == 6'd1) state <= S_SPACE;
        end
        S_SPACE: begin
          if (!found || space < gap) gap <= space;
          found <= 1'b1;
          if (space < 0) begin
            state <= S_GROW;
          end else begin
            j_cnt <= j_cnt + 1'b1;
            state <= S_JCHK;
          end
        end
        S_GROW: state <= S_NEW;
        S_NEW: begin
          state <= S_NSQ;
        end
        S_NSQ: state <= S_NACC;
        S_NACC: begin
          new_sum <= new_add[64] ? '1 : new_add[63:0];
          i_cnt   <= i_cnt + 1'b1;
          state   <= (i_cnt + 1'b1 == circle_count) ? S_PEND : S_ISTART;
        end
        S_PEND: begin
          pass_count <= pass_count + 1'b1;
          state <= (old_sum != '0 && new_sum > old_sum) ? S_RLO : S_EMIT;
        end
        S_RLO: state <= S_RHI;
        S_RHI: begin
          rlo   <= prod[47:0];
          state <= S_CMP;
        end
        S_CMP: state <= (lhs > rhs) ? S_PSTART : S_EMIT;
        S_EMIT: begin
          e_cnt <= '0;
          if (circle_count == '0) begin
            out_x       <= '0;
            out_y       <= '0;
            out_radius  <= '0;
            last_out    <= 1'b1;
            none_stored <= 1'b1;
            passes_done <= pass_count;
            out_valid   <= 1'b1;
            state       <= S_EWAIT;
          end else begin
            state <= S_EREAD;
          end
        end
        S_EREAD: state <= S_ELOAD;
        S_ELOAD: begin
          out_x       <= rx;
          out_y       <= ry;
          out_radius  <= {1'b0, rd[31:1]};
          last_out    <= (e_cnt + 1'b1 == circle_count);
          none_stored <= 1'b0;
          passes_done <= pass_count;
          out_valid   <= 1'b1;
          state       <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_out) begin
              circle_count <= '0;
              state        <= S_IDLE;
            end else begin
              e_cnt <= e_cnt + 1'b1;
              state <= S_EREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // new diameter, saturated at both ends
  always_ff @(posedge clk) begin
    if (state == S_NEW) begin
      if (nd_wide[35]) nd <= '0;
      else if (|nd_wide[34:32]) nd <= '1;
      else nd <= nd_wide[31:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/cpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpg_checker
// port level checks for the circle packing growth pass block
// ----------------------------------------------------------------------------
module cpg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [31:0] out_x,
  input wire logic       last_out,
  input wire logic       none_stored
);

  // no new request while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while emitting");

  // empty set result is the final one
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_stored |-> last_out) else $error("empty result not last");

  // set ends after the last result is taken
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> !out_valid) else $error("result after last");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x)) else $error("result dropped");

endmodule

bind circle_packing_grow_pass_top cpg_checker u_cpg_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_x(out_x), .last_out(last_out),
  .none_stored(none_stored)
);
`default_nettype wire
